// File: hw/rtl/char_lcd_parallel_bus_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD bus sequencer
// Short forms of the concurrent assertions used in clpb_core.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_PARALLEL_BUS_SEQUENCER_MACROS_SVH
`define CHAR_LCD_PARALLEL_BUS_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("clpb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("clpb assertion failed");

`endif

// File: hw/rtl/clpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpb_pkg
// Types, codes and constants shared by the LCD bus sequencer modules.
// ----------------------------------------------------------------------------
package clpb_pkg;

    localparam int ByteW    = 8;
    localparam int TickW    = 8;
    localparam int RetryW   = 12;
    localparam int CfgDataW = 12;
    localparam int CfgIdxW  = 2;
    localparam int BusyBit  = 7;

    localparam logic [TickW-1:0]  SetupTicksRst = TickW'(15);
    localparam logic [TickW-1:0]  PulseTicksRst = TickW'(36);
    localparam logic [TickW-1:0]  HoldTicksRst  = TickW'(22);
    localparam logic [RetryW-1:0] MaxRetriesRst = RetryW'(1000);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_PULSE = 3'd2,
        PH_HOLD  = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CMD    = 2'd1,
        OP_DATA   = 2'd2,
        OP_STATUS = 2'd3
    } t_opcode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SETUP   = 2'd0,
        CFG_PULSE   = 2'd1,
        CFG_HOLD    = 2'd2,
        CFG_RETRIES = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TickW-1:0]  setup_ticks;
        logic [TickW-1:0]  pulse_ticks;
        logic [TickW-1:0]  hold_ticks;
        logic [RetryW-1:0] max_retries;
    } t_cfg;

    typedef struct packed {
        logic             enable_pin;
        logic             select_pin;
        logic             read_pin;
        logic [ByteW-1:0] data_out;
        logic             drive_data;
        logic             ready_res;
        logic             done_res;
        logic [ByteW-1:0] status_byte;
        logic             timed_out;
    } t_result;

    // A phase length of zero behaves as one tick.
    function automatic logic [TickW-1:0] eff_len(input logic [TickW-1:0] v);
        eff_len = (v == '0) ? TickW'(1) : v;
    endfunction

endpackage

// File: hw/rtl/clpb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpb_in_if
// Request channel: one transfer per bus timing tick.
// ----------------------------------------------------------------------------
interface clpb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic [7:0] bus_in;

    modport source (output valid, output opcode, output byte_value, output bus_in,
                    input ready);
    modport sink (input valid, input opcode, input byte_value, input bus_in,
                  output ready);
endinterface

// File: hw/rtl/clpb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpb_out_if
// Result channel: pin levels and status after each tick.
// ----------------------------------------------------------------------------
interface clpb_out_if;
    logic       valid;
    logic       ready;
    logic       enable_pin;
    logic       select_pin;
    logic       read_pin;
    logic [7:0] data_out;
    logic       drive_data;
    logic       ready_res;
    logic       done_res;
    logic [7:0] status_byte;
    logic       timed_out;

    modport source (output valid, output enable_pin, output select_pin,
                    output read_pin, output data_out, output drive_data,
                    output ready_res, output done_res, output status_byte,
                    output timed_out, input ready);
    modport sink (input valid, input enable_pin, input select_pin,
                  input read_pin, input data_out, input drive_data,
                  input ready_res, input done_res, input status_byte,
                  input timed_out, output ready);
endinterface

// File: hw/rtl/clpb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpb_cfg
// Timing and retry configuration registers with a plain write port.
// ----------------------------------------------------------------------------
module clpb_cfg
    import clpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [CfgIdxW-1:0]  i_index,
    input  logic [CfgDataW-1:0] i_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_ticks <= SetupTicksRst;
            r_cfg.pulse_ticks <= PulseTicksRst;
            r_cfg.hold_ticks  <= HoldTicksRst;
            r_cfg.max_retries <= MaxRetriesRst;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_index))
                CFG_SETUP:   r_cfg.setup_ticks <= i_data[TickW-1:0];
                CFG_PULSE:   r_cfg.pulse_ticks <= i_data[TickW-1:0];
                CFG_HOLD:    r_cfg.hold_ticks  <= i_data[TickW-1:0];
                CFG_RETRIES: r_cfg.max_retries <= i_data[RetryW-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/clpb_core.sv
`timescale 1ns / 1ps
`include "char_lcd_parallel_bus_sequencer_macros.svh"
// ----------------------------------------------------------------------------
// clpb_core
// Bus cycle sequencer state and its single-tick next-state logic.
// ----------------------------------------------------------------------------
module clpb_core
    import clpb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_opcode          i_opcode,
    input  logic [ByteW-1:0] i_byte_value,
    input  logic [ByteW-1:0] i_bus_in,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    t_phase            r_phase,   n_phase;
    logic [TickW-1:0]  r_count,   n_count;
    logic [RetryW-1:0] r_retry,   n_retry;
    logic              r_en,      n_en;
    logic              r_rs,      n_rs;
    logic              r_rw,      n_rw;
    logic [ByteW-1:0]  r_held,    n_held;
    logic              r_drive,   n_drive;
    logic              r_pending, n_pending;
    logic [ByteW-1:0]  r_status,  n_status;
    logic              r_timeout, n_timeout;
    logic              n_done;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_retry   = r_retry;
        n_en      = r_en;
        n_rs      = r_rs;
        n_rw      = r_rw;
        n_held    = r_held;
        n_drive   = r_drive;
        n_pending = r_pending;
        n_status  = r_status;
        n_timeout = r_timeout;
        n_done    = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                unique case (i_opcode)
                    OP_CMD: begin
                        n_held    = i_byte_value;
                        n_pending = 1'b0;
                        n_en      = 1'b0;
                        n_rs      = 1'b0;
                        n_rw      = 1'b0;
                        n_drive   = 1'b1;
                        n_phase   = PH_SETUP;
                        n_count   = TickW'(1);
                    end
                    OP_DATA, OP_STATUS: begin
                        if (i_opcode == OP_DATA) begin
                            n_held = i_byte_value;
                        end
                        n_pending = (i_opcode == OP_DATA);
                        n_retry   = '0;
                        n_timeout = 1'b0;
                        n_en      = 1'b0;
                        n_rs      = 1'b0;
                        n_rw      = 1'b1;
                        n_drive   = 1'b0;
                        n_phase   = PH_SETUP;
                        n_count   = TickW'(1);
                    end
                    OP_TICK: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            PH_SETUP: begin
                if (r_count < eff_len(i_cfg.setup_ticks)) begin
                    n_count = r_count + TickW'(1);
                end else begin
                    n_phase = PH_PULSE;
                    n_count = TickW'(1);
                    n_en    = 1'b1;
                end
            end
            PH_PULSE: begin
                if (r_count < eff_len(i_cfg.pulse_ticks)) begin
                    n_count = r_count + TickW'(1);
                end else begin
                    n_phase = PH_HOLD;
                    n_count = TickW'(1);
                    n_en    = 1'b0;
                end
            end
            PH_HOLD: begin
                if (r_count < eff_len(i_cfg.hold_ticks)) begin
                    n_count = r_count + TickW'(1);
                end else if (r_rw && r_status[BusyBit] && (r_retry < i_cfg.max_retries)) begin
                    n_retry = r_retry + RetryW'(1);
                    n_en    = 1'b0;
                    n_rs    = 1'b0;
                    n_rw    = 1'b1;
                    n_drive = 1'b0;
                    n_phase = PH_SETUP;
                    n_count = TickW'(1);
                end else if (r_rw && r_pending) begin
                    n_timeout = r_timeout | r_status[BusyBit];
                    n_pending = 1'b0;
                    n_en      = 1'b0;
                    n_rs      = 1'b1;
                    n_rw      = 1'b0;
                    n_drive   = 1'b1;
                    n_phase   = PH_SETUP;
                    n_count   = TickW'(1);
                end else begin
                    n_timeout = r_timeout | (r_rw & r_status[BusyBit]);
                    n_phase   = PH_IDLE;
                    n_count   = '0;
                    n_done    = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
                n_en    = 1'b0;
            end
        endcase

        if ((n_phase == PH_PULSE) && (n_count >= eff_len(i_cfg.pulse_ticks)) && n_rw) begin
            n_status = i_bus_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_retry   <= '0;
            r_en      <= 1'b0;
            r_rs      <= 1'b0;
            r_rw      <= 1'b0;
            r_held    <= '0;
            r_drive   <= 1'b0;
            r_pending <= 1'b0;
            r_status  <= '0;
            r_timeout <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_retry   <= n_retry;
            r_en      <= n_en;
            r_rs      <= n_rs;
            r_rw      <= n_rw;
            r_held    <= n_held;
            r_drive   <= n_drive;
            r_pending <= n_pending;
            r_status  <= n_status;
            r_timeout <= n_timeout;
        end
    end

    always_comb begin
        o_result.enable_pin  = n_en;
        o_result.select_pin  = n_rs;
        o_result.read_pin    = n_rw;
        o_result.data_out    = n_drive ? n_held : '0;
        o_result.drive_data  = n_drive;
        o_result.ready_res   = (n_phase == PH_IDLE);
        o_result.done_res    = n_done;
        o_result.status_byte = n_status;
        o_result.timed_out   = n_timeout;
    end

    `CLPB_ASSERT_IMP(a_enable_in_pulse, i_clk, i_rst_n, 1'b1, r_en == (r_phase == PH_PULSE))
    `CLPB_ASSERT_IMP(a_read_releases_bus, i_clk, i_rst_n, r_rw, !r_drive)
    `CLPB_ASSERT_NEXT(a_cmd_starts_write, i_clk, i_rst_n,
        i_step && (r_phase == PH_IDLE) && (i_opcode == OP_CMD),
        (r_phase == PH_SETUP) && r_drive && !r_rw && !r_rs)

endmodule

// File: hw/rtl/char_lcd_parallel_bus_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_parallel_bus_sequencer
// Each transfer on the request channel is one tick of the LCD bus timing, and
// it yields exactly one result transfer showing the pin levels and status
// after that tick; a new request is taken every clock cycle while the result
// channel is not stalled, and a request passes through the input register and
// then the result register, with the result register and its valid bit
// letting the next request enter while a finished result still waits.
// ----------------------------------------------------------------------------
module char_lcd_parallel_bus_sequencer
    import clpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    clpb_in_if.sink             i_in,
    clpb_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic             r_in_valid;
    t_opcode          r_opcode;
    logic [ByteW-1:0] r_byte_value;
    logic [ByteW-1:0] r_bus_in;
    logic             r_out_valid;
    t_result          r_out;
    logic             w_advance;
    t_cfg             w_cfg;
    t_result          w_result;

    assign w_advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_opcode     <= t_opcode'(i_in.opcode);
            r_byte_value <= i_in.byte_value;
            r_bus_in     <= i_in.bus_in;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    clpb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    clpb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_opcode     (r_opcode),
        .i_byte_value (r_byte_value),
        .i_bus_in     (r_bus_in),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.enable_pin  = r_out.enable_pin;
    assign o_out.select_pin  = r_out.select_pin;
    assign o_out.read_pin    = r_out.read_pin;
    assign o_out.data_out    = r_out.data_out;
    assign o_out.drive_data  = r_out.drive_data;
    assign o_out.ready_res   = r_out.ready_res;
    assign o_out.done_res    = r_out.done_res;
    assign o_out.status_byte = r_out.status_byte;
    assign o_out.timed_out   = r_out.timed_out;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character LCD parallel bus sequencer. Every
// request transfer is one bus timing tick and yields one result transfer. A
// predictor of the bus sequencing forecasts the pin levels for each accepted
// tick, and each result is compared field by field with the oldest forecast.
// A short directed script is followed by random phases under several timing
// settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import clpb_pkg::*;

    typedef enum int {
        CYC_READ,
        CYC_CMD,
        CYC_DATA
    } t_cycle_kind;

    typedef struct packed {
        logic              is_cfg;
        t_cfg_idx          reg_idx;
        logic [CfgDataW-1:0] reg_val;
        t_opcode           op;
        logic [ByteW-1:0]  chr;
        logic [ByteW-1:0]  bus;
        logic              typed;
        t_result           want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    t_cfg_idx            cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    clpb_in_if  req_if ();
    clpb_out_if res_if ();

    char_lcd_parallel_bus_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    t_cfg             timing;
    t_phase           lcd_phase;
    logic [TickW-1:0] tick_count;
    logic [RetryW-1:0] poll_count;
    logic             en_lvl;
    logic             rs_lvl;
    logic             rw_lvl;
    logic [ByteW-1:0] held_char;
    logic             driving;
    logic             write_waiting;
    logic [ByteW-1:0] busy_sample;
    logic             gave_up;

    t_result pin_forecast[$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      mismatches = 0;
    int      results_checked = 0;
    int      requests_done = 0;
    int      busy_timeouts = 0;
    int      ticks_sent = 0;

    function automatic logic [TickW-1:0] phase_len(input logic [TickW-1:0] v);
        phase_len = (v == '0) ? TickW'(1) : v;
    endfunction

    task automatic begin_bus_cycle(input t_cycle_kind kind);
        en_lvl = 1'b0;
        rs_lvl = (kind == CYC_DATA);
        rw_lvl = (kind == CYC_READ);
        driving = (kind != CYC_READ);
        lcd_phase = PH_SETUP;
        tick_count = TickW'(1);
    endtask

    task automatic finish_bus_cycle(output logic finished);
        finished = 1'b0;
        if (rw_lvl && busy_sample[BusyBit] && poll_count < timing.max_retries) begin
            poll_count = poll_count + 1'b1;
            begin_bus_cycle(CYC_READ);
        end else if (rw_lvl && write_waiting) begin
            if (busy_sample[BusyBit]) gave_up = 1'b1;
            write_waiting = 1'b0;
            begin_bus_cycle(CYC_DATA);
        end else begin
            if (rw_lvl && busy_sample[BusyBit]) gave_up = 1'b1;
            lcd_phase = PH_IDLE;
            tick_count = '0;
            finished = 1'b1;
        end
    endtask

    task automatic reset_predictor();
        timing.setup_ticks = SetupTicksRst;
        timing.pulse_ticks = PulseTicksRst;
        timing.hold_ticks = HoldTicksRst;
        timing.max_retries = MaxRetriesRst;
        lcd_phase = PH_IDLE;
        tick_count = '0;
        poll_count = '0;
        en_lvl = 1'b0;
        rs_lvl = 1'b0;
        rw_lvl = 1'b0;
        held_char = '0;
        driving = 1'b0;
        write_waiting = 1'b0;
        busy_sample = '0;
        gave_up = 1'b0;
    endtask

    task automatic advance_lcd_bus(input t_opcode op, input logic [ByteW-1:0] chr,
                                   input logic [ByteW-1:0] bus, output t_result r);
        logic finished;
        finished = 1'b0;
        case (lcd_phase)
            PH_IDLE: begin
                if (op == OP_CMD) begin
                    held_char = chr;
                    write_waiting = 1'b0;
                    begin_bus_cycle(CYC_CMD);
                end else if (op == OP_DATA || op == OP_STATUS) begin
                    if (op == OP_DATA) held_char = chr;
                    write_waiting = (op == OP_DATA);
                    poll_count = '0;
                    gave_up = 1'b0;
                    begin_bus_cycle(CYC_READ);
                end
            end
            PH_SETUP: begin
                if (tick_count < phase_len(timing.setup_ticks)) begin
                    tick_count = tick_count + 1'b1;
                end else begin
                    lcd_phase = PH_PULSE;
                    tick_count = TickW'(1);
                    en_lvl = 1'b1;
                end
            end
            PH_PULSE: begin
                if (tick_count < phase_len(timing.pulse_ticks)) begin
                    tick_count = tick_count + 1'b1;
                end else begin
                    lcd_phase = PH_HOLD;
                    tick_count = TickW'(1);
                    en_lvl = 1'b0;
                end
            end
            PH_HOLD: begin
                if (tick_count < phase_len(timing.hold_ticks)) begin
                    tick_count = tick_count + 1'b1;
                end else begin
                    finish_bus_cycle(finished);
                end
            end
            default: begin
                lcd_phase = PH_IDLE;
                tick_count = '0;
                en_lvl = 1'b0;
            end
        endcase
        if (lcd_phase == PH_PULSE && tick_count >= phase_len(timing.pulse_ticks) && rw_lvl)
            busy_sample = bus;
        r.enable_pin = en_lvl;
        r.select_pin = rs_lvl;
        r.read_pin = rw_lvl;
        r.data_out = driving ? held_char : '0;
        r.drive_data = driving;
        r.ready_res = (lcd_phase == PH_IDLE);
        r.done_res = finished;
        r.status_byte = busy_sample;
        r.timed_out = gave_up;
    endtask

    task automatic send_tick(input t_opcode op, input logic [ByteW-1:0] chr,
                             input logic [ByteW-1:0] bus, input logic typed,
                             input t_result typed_want);
        t_result forecast;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.opcode <= op;
        req_if.byte_value <= chr;
        req_if.bus_in <= bus;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        advance_lcd_bus(op, chr, bus, forecast);
        pin_forecast.push_back(typed ? typed_want : forecast);
        ticks_sent++;
    endtask

    // Runs the sequencer back to idle, then waits for every forecast to be checked.
    task automatic settle();
        while (lcd_phase != PH_IDLE)
            send_tick(OP_TICK, 8'($urandom), 8'($urandom_range(0, 127)), 1'b0, '0);
        req_if.valid <= 1'b0;
        while (pin_forecast.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] val);
        case (idx)
            CFG_SETUP:   timing.setup_ticks = val[TickW-1:0];
            CFG_PULSE:   timing.pulse_ticks = val[TickW-1:0];
            CFG_HOLD:    timing.hold_ticks = val[TickW-1:0];
            CFG_RETRIES: timing.max_retries = val[RetryW-1:0];
            default:     ;
        endcase
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int s_idle, input int r_stall, input int setup,
                             input int pulse, input int hold, input int retries,
                             input int count);
        logic [ByteW-1:0] bus;
        settle();
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        write_reg(CFG_SETUP, CfgDataW'(setup));
        write_reg(CFG_PULSE, CfgDataW'(pulse));
        write_reg(CFG_HOLD, CfgDataW'(hold));
        write_reg(CFG_RETRIES, CfgDataW'(retries));
        for (int n = 0; n < count; n++) begin
            bus = 8'($urandom);
            bus[BusyBit] = ($urandom_range(0, 99) < 60);
            send_tick(t_opcode'($urandom_range(0, 3)), 8'($urandom), bus, 1'b0, '0);
        end
    endtask

    function automatic t_dir_row tick_row(input t_opcode op, input logic [ByteW-1:0] chr,
                                          input logic [ByteW-1:0] bus, input logic typed,
                                          input t_result want);
        tick_row = '0;
        tick_row.op = op;
        tick_row.chr = chr;
        tick_row.bus = bus;
        tick_row.typed = typed;
        tick_row.want = want;
    endfunction

    function automatic t_dir_row reg_row(input t_cfg_idx idx, input int val);
        reg_row = '0;
        reg_row.is_cfg = 1'b1;
        reg_row.reg_idx = idx;
        reg_row.reg_val = CfgDataW'(val);
    endfunction

    function automatic string show(input t_result r);
        show = $sformatf("en=%0b rs=%0b rw=%0b data=%02h drv=%0b rdy=%0b done=%0b st=%02h to=%0b",
                         r.enable_pin, r.select_pin, r.read_pin, r.data_out, r.drive_data,
                         r.ready_res, r.done_res, r.status_byte, r.timed_out);
    endfunction

    initial begin : result_sink
        t_result got;
        t_result want;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.enable_pin = res_if.enable_pin;
                got.select_pin = res_if.select_pin;
                got.read_pin = res_if.read_pin;
                got.data_out = res_if.data_out;
                got.drive_data = res_if.drive_data;
                got.ready_res = res_if.ready_res;
                got.done_res = res_if.done_res;
                got.status_byte = res_if.status_byte;
                got.timed_out = res_if.timed_out;
                if (pin_forecast.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %s", show(got));
                end else begin
                    want = pin_forecast.pop_front();
                    results_checked++;
                    if (got.done_res === 1'b1) requests_done++;
                    if (got.done_res === 1'b1 && got.timed_out === 1'b1) busy_timeouts++;
                    if (got.enable_pin !== want.enable_pin ||
                        got.select_pin !== want.select_pin ||
                        got.read_pin !== want.read_pin ||
                        got.data_out !== want.data_out ||
                        got.drive_data !== want.drive_data ||
                        got.ready_res !== want.ready_res ||
                        got.done_res !== want.done_res ||
                        got.status_byte !== want.status_byte ||
                        got.timed_out !== want.timed_out) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch on result %0d", results_checked);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
            res_if.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_dir_row script[$];
        t_result  after_reset;
        t_result  gave_up_idle;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SETUP;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.opcode = OP_TICK;
        req_if.byte_value = '0;
        req_if.bus_in = '0;
        reset_predictor();

        after_reset = '0;
        after_reset.ready_res = 1'b1;
        gave_up_idle = '0;
        gave_up_idle.read_pin = 1'b1;
        gave_up_idle.ready_res = 1'b1;
        gave_up_idle.done_res = 1'b1;
        gave_up_idle.status_byte = 8'hFF;
        gave_up_idle.timed_out = 1'b1;

        // Reset timing first, then the shortest bus cycles with one retry allowed.
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b1, after_reset));
        script.push_back(reg_row(CFG_SETUP, 0));
        script.push_back(reg_row(CFG_PULSE, 1));
        script.push_back(reg_row(CFG_HOLD, 0));
        script.push_back(reg_row(CFG_RETRIES, 1));
        // Status read that stays busy through both polls and times out.
        script.push_back(tick_row(OP_STATUS, 8'h00, 8'hFF, 1'b0, '0));
        script.push_back(tick_row(OP_CMD, 8'hAA, 8'hFF, 1'b0, '0));
        script.push_back(tick_row(OP_DATA, 8'h55, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'hFF, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b1, gave_up_idle));
        // Data write whose busy poll clears at once.
        script.push_back(tick_row(OP_DATA, 8'hFF, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_STATUS, 8'h00, 8'h7F, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        // No retries: the data write goes ahead after a busy timeout.
        script.push_back(reg_row(CFG_RETRIES, 0));
        script.push_back(tick_row(OP_DATA, 8'h81, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h80, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        // Command write, which leaves the timeout flag as it is.
        script.push_back(tick_row(OP_CMD, 8'h00, 8'h80, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));
        script.push_back(tick_row(OP_TICK, 8'h00, 8'h00, 1'b0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                settle();
                write_reg(script[k].reg_idx, script[k].reg_val);
            end else begin
                send_tick(script[k].op, script[k].chr, script[k].bus,
                          script[k].typed, script[k].want);
            end
        end

        run_phase(0, 0, 1, 1, 1, 3, 450);
        run_phase(86, 0, 0, 0, 0, 0, 400);
        run_phase(0, 86, $urandom_range(1, 4), $urandom_range(1, 4),
                  $urandom_range(1, 4), 2, 400);
        run_phase(6, 6, 2, 1, 3, 4095, 400);
        run_phase(0, 0, 255, 255, 255, 0, 300);
        settle();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results from %0d ticks; %0d requests finished, %0d after a busy timeout.",
                 results_checked, ticks_sent, requests_done, busy_timeouts);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
